[src/nppd_pkg.sv]
// Shared widths, request codes and status codes for the nearest path point block.
`default_nettype none

package nppd_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int DIST_W   = 17;
  localparam int COUNT_W  = 9;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_ADD   = 2'd0;
  localparam req_t REQ_QUERY = 2'd1;

  localparam status_t ST_ADDED   = 3'd0;
  localparam status_t ST_VALID   = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_EMPTY   = 3'd3;
  localparam status_t ST_CLEARED = 3'd4;

endpackage

`default_nettype wire

[src/nppd_if.sv]
// Request and result channel interfaces of the nearest path point block.
`default_nettype none

interface nppd_in_if
  import nppd_pkg::*;
#(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  req_t                         req_type;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface nppd_out_if
  import nppd_pkg::*;
();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [DIST_W-1:0]  distance;
  logic [COUNT_W-1:0] point_count;

  modport source (output valid, status, distance, point_count, input ready);
  modport sink   (input valid, status, distance, point_count, output ready);
endinterface

`default_nettype wire

[src/nearest_path_point_distance.sv]
// Path point store with a nearest point distance query (linear scan and integer square root).
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_ch    | in  | valid / ready | req_type, coord_x, coord_y, coord_z
//  out_ch   | out | valid / ready | status, distance, point_count
//
// One request is in work at a time. An add or clear goes straight to RESP, which loads its
// result into the output register once that register is free, then returns to IDLE for the next
// request. A query over N stored points feeds N reads into a four stage distance pipeline, then
// runs COORD_BITS + 2 square root steps before its result goes through RESP in the same way.
// Reset (rst_n, synchronous) empties the store; memory contents are not cleared.
// A result waits in the output register while the next request is accepted.
`default_nettype none

module nearest_path_point_distance
  import nppd_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  nppd_in_if.sink   in_ch,
  nppd_out_if.source out_ch
);

  localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PT_W    = 3 * COORD_BITS;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ1_W   = 2 * DIFF_W;
  localparam int SQ_W    = 2 * COORD_BITS + 4;

  typedef enum logic [1:0] {IDLE, SCAN, SQRT, RESP} state_t;

  state_t state_r;

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [3:0]        v_r;
  logic [SQ_W-1:0]   best_r;
  logic [SQ_W-1:0]   rem_r;
  logic [SQ_W-1:0]   res_r;
  logic [SQ_W-1:0]   bit_r;

  logic signed [COORD_BITS-1:0] q_x_r, q_y_r, q_z_r;

  status_t            resp_status_r;
  logic [DIST_W-1:0]  resp_dist_r;
  logic [CNT_W-1:0]   resp_count_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [COUNT_W-1:0] out_count_r;

  // Point memory, one {x, y, z} word per entry.
  logic [PT_W-1:0] mem [MAX_POINTS];
  logic [PT_W-1:0] rdata_r;

  logic [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [SQ1_W-1:0]  sx_r, sy_r, sz_r;
  logic [SQ_W-1:0]   sum_r;

  logic            in_acc;
  logic            full;
  logic            mem_we;
  logic            rd_en;
  logic [SQ_W-1:0] sq_trial;
  logic            sq_take;

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_BITS-1:0] a,
                                                 logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign in_ch.ready = (state_r == IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(MAX_POINTS));
  assign mem_we      = in_acc && (in_ch.req_type == REQ_ADD) && !full;
  assign rd_en       = (state_r == SCAN) && (rd_idx_r < cnt_r);

  assign sq_trial = res_r + bit_r;
  assign sq_take  = (rem_r >= sq_trial);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.distance    = out_dist_r;
  assign out_ch.point_count = out_count_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // Distance pipeline: differences, squares, sum. The minimum is kept in best_r.
  always_ff @(posedge clk) begin
    dx_r  <= abs_diff(rdata_r[PT_W-1 -: COORD_BITS], q_x_r);
    dy_r  <= abs_diff(rdata_r[2*COORD_BITS-1 -: COORD_BITS], q_y_r);
    dz_r  <= abs_diff(rdata_r[COORD_BITS-1:0], q_z_r);
    sx_r  <= dx_r * dx_r;
    sy_r  <= dy_r * dy_r;
    sz_r  <= dz_r * dz_r;
    sum_r <= SQ_W'(sx_r) + SQ_W'(sy_r) + SQ_W'(sz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r <= {v_r[2:0], rd_en};
      if (v_r[3] && (sum_r < best_r)) begin
        best_r <= sum_r;
      end
      if (out_ch.ready && (state_r != RESP)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        IDLE: begin
          if (in_acc) begin
            q_x_r       <= in_ch.coord_x;
            q_y_r       <= in_ch.coord_y;
            q_z_r       <= in_ch.coord_z;
            resp_dist_r <= '0;
            // A request code with its high bit set acts as a clear.
            if (in_ch.req_type[REQ_W-1]) begin
              cnt_r         <= '0;
              resp_count_r  <= '0;
              resp_status_r <= ST_CLEARED;
              state_r       <= RESP;
            end else if (in_ch.req_type == REQ_ADD) begin
              if (full) begin
                resp_count_r  <= cnt_r;
                resp_status_r <= ST_FULL;
              end else begin
                cnt_r         <= cnt_r + 1'b1;
                resp_count_r  <= cnt_r + 1'b1;
                resp_status_r <= ST_ADDED;
              end
              state_r <= RESP;
            end else if (cnt_r == '0) begin
              resp_count_r  <= cnt_r;
              resp_status_r <= ST_EMPTY;
              state_r       <= RESP;
            end else begin
              rd_idx_r <= '0;
              best_r   <= '1;
              state_r  <= SCAN;
            end
          end
        end
        SCAN: begin
          if (rd_en) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end else if (v_r == '0) begin
            rem_r   <= best_r;
            res_r   <= '0;
            bit_r   <= SQ_W'(1) << (SQ_W - 2);
            state_r <= SQRT;
          end
        end
        SQRT: begin
          if (bit_r != '0) begin
            if (sq_take) begin
              rem_r <= rem_r - sq_trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            resp_dist_r   <= DIST_W'(res_r);
            resp_status_r <= ST_VALID;
            resp_count_r  <= cnt_r;
            state_r       <= RESP;
          end
        end
        RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= resp_status_r;
            out_dist_r   <= resp_dist_r;
            out_count_r  <= COUNT_W'(resp_count_r);
            state_r      <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("stored point count above store depth");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r != '0) |-> (state_r == SCAN))
    else $error("distance pipeline busy outside the scan");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_idx_r < cnt_r) && (cnt_r != '0))
    else $error("scan read beyond stored points");

  a_dist_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_VALID)) |-> (out_dist_r == '0))
    else $error("nonzero distance on a result without a distance");

  a_sqrt_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == SCAN && state_r == SQRT) |-> (rem_r == $past(best_r)))
    else $error("square root did not start from the scan minimum");

endmodule

`default_nettype wire
